/* rtl/rri_pkg.sv */
// Package of types, constants and functions for the ray rectangle intersect unit.
`default_nettype none
package rri_pkg;

  localparam int FracBits = 16;
  localparam int MinDirQ  = 1;
  localparam int CoordW   = 32;
  localparam int ProdW    = 64;
  localparam int NumW     = CoordW + FracBits;   // dividend width
  localparam int KW       = NumW;                // quotient width
  localparam int DistW    = 31;

  // Register indexes.
  localparam logic [2:0] RegXA = 3'd0;
  localparam logic [2:0] RegXB = 3'd1;
  localparam logic [2:0] RegYA = 3'd2;
  localparam logic [2:0] RegYB = 3'd3;
  localparam logic [2:0] RegZA = 3'd4;
  localparam logic [2:0] RegZB = 3'd5;
  localparam logic [2:0] RegW  = 3'd6;
  localparam logic [2:0] RegH  = 3'd7;

  // Saturate a wide sum to the signed coordinate range.
  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [CoordW+2:0] v);
    logic signed [CoordW+2:0] hi;
    logic signed [CoordW+2:0] lo;
    hi = (CoordW+3)'(signed'({1'b0, {(CoordW-1){1'b1}}}));
    lo = -hi - (CoordW+3)'(1);
    if (v > hi)      sat_coord = hi[CoordW-1:0];
    else if (v < lo) sat_coord = lo[CoordW-1:0];
    else             sat_coord = v[CoordW-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/ray_rectangle_intersect_unit.sv */
// Top level of the ray rectangle intersect unit: transform, divide and bound test.
//
//  channel | signals                              | direction
//  in      | in_valid, in_ready, origin_*, dir_*  | into block
//  out     | out_valid, out_ready, hit, distance  | out of block
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | into block
//
// One ray enters per cycle while the output is not stalled; a ray passes 3 + KW + 3
// register stages (54), set by the restoring divider, which retires one quotient bit per stage.
// Reset (synchronous) clears every valid bit; payload registers are not reset.
// A stall on the output freezes the whole pipeline; no word is lost or repeated.
`default_nettype none
module ray_rectangle_intersect_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [31:0]  origin_x,
  input  wire logic signed [31:0]  origin_y,
  input  wire logic signed [31:0]  origin_z,
  input  wire logic signed [31:0]  direction_x,
  input  wire logic signed [31:0]  direction_y,
  input  wire logic signed [31:0]  direction_z,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     hit,
  output logic [30:0]              distance,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_data
);

  localparam int CW = rri_pkg::CoordW;
  localparam int FB = rri_pkg::FracBits;
  localparam int KW = rri_pkg::KW;
  localparam int NS = KW;            // divider stages
  localparam int PW = 2*CW;

  // Configuration registers.
  logic [63:0] xa, xb, ya, yb, za, zb;
  logic [15:0] rw, rh;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      xa <= 64'h1_0000_0000; xb <= '0; ya <= 64'h1_0000; yb <= '0;
      za <= '0; zb <= 64'h1_0000_0000; rw <= 16'd1; rh <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        rri_pkg::RegXA: xa <= cfg_data;
        rri_pkg::RegXB: xb <= cfg_data;
        rri_pkg::RegYA: ya <= cfg_data;
        rri_pkg::RegYB: yb <= cfg_data;
        rri_pkg::RegZA: za <= cfg_data;
        rri_pkg::RegZB: zb <= cfg_data;
        rri_pkg::RegW:  rw <= cfg_data[15:0];
        rri_pkg::RegH:  rh <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances when the output word is free or being taken.
  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: eighteen products (floor shift), one multiplier each.
  logic v1;
  logic signed [CW-1:0] c [9];
  logic signed [CW-1:0] t [3];
  logic signed [CW-1:0] pr [18];
  logic signed [CW-1:0] vin [6];
  logic signed [PW-1:0] full [18];

  always_comb begin
    c[0] = xa[63:32]; c[1] = xa[31:0]; c[2] = xb[63:32];
    c[3] = ya[63:32]; c[4] = ya[31:0]; c[5] = yb[63:32];
    c[6] = za[63:32]; c[7] = za[31:0]; c[8] = zb[63:32];
    t[0] = xb[31:0]; t[1] = yb[31:0]; t[2] = zb[31:0];
    vin[0] = origin_x; vin[1] = origin_y; vin[2] = origin_z;
    vin[3] = direction_x; vin[4] = direction_y; vin[5] = direction_z;
    for (int r = 0; r < 3; r++)
      for (int j = 0; j < 3; j++) begin
        full[r*3+j]     = PW'(c[r*3+j]) * PW'(vin[j]);
        full[9+r*3+j]   = PW'(c[r*3+j]) * PW'(vin[3+j]);
      end
  end

  logic signed [PW-FB-1:0] pw1 [18];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
    if (adv)
      for (int i = 0; i < 18; i++) pw1[i] <= full[i][PW-1:FB];
  end

  // Stage 2: row sums, with translation on the origin rows only, saturated.
  logic v2;
  logic signed [CW-1:0] px, py, pz, lx, ly, lz;
  logic signed [PW-FB+1:0] s [6];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s[r] = (PW-FB+2)'(pw1[r*3]) + (PW-FB+2)'(pw1[r*3+1]) + (PW-FB+2)'(pw1[r*3+2])
           + (PW-FB+2)'(t[r]);
      s[3+r] = (PW-FB+2)'(pw1[9+r*3]) + (PW-FB+2)'(pw1[9+r*3+1])
             + (PW-FB+2)'(pw1[9+r*3+2]);
    end
  end

  function automatic logic signed [CW-1:0] sat(input logic signed [PW-FB+1:0] v);
    if (v > (PW-FB+2)'(64'sh7FFF_FFFF)) sat = 32'sh7FFF_FFFF;
    else if (v < -(PW-FB+2)'(64'sh8000_0000)) sat = 32'sh8000_0000;
    else sat = v[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      px <= sat(s[0]); py <= sat(s[1]); pz <= sat(s[2]);
      lx <= sat(s[3]); ly <= sat(s[4]); lz <= sat(s[5]);
    end
  end

  // Stage 3: reject test and divider operands.
  logic v3, rej3;
  logic [KW-1:0] num3;
  logic [CW:0] den3;
  logic signed [CW-1:0] px3, py3, lx3, ly3;
  logic [CW:0] dmag;
  assign dmag = lz[CW-1] ? -(CW+1)'(lz) : (CW+1)'(lz);

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      rej3 <= (dmag < (CW+1)'(rri_pkg::MinDirQ)) ||
              ((pz != '0) && (pz[CW-1] == lz[CW-1]));
      num3 <= KW'(pz[CW-1] ? -(CW+1)'(pz) : (CW+1)'(pz)) << FB;
      den3 <= dmag;
      px3 <= px; py3 <= py; lx3 <= lx; ly3 <= ly;
    end
  end

  // Divider: one restoring step per stage.
  logic          dv   [NS+1];
  logic          drej [NS+1];
  logic [KW-1:0] dq   [NS+1];
  logic [CW:0]   drm  [NS+1];
  logic [KW-1:0] dn   [NS+1];
  logic [CW:0]   dd   [NS+1];
  logic signed [CW-1:0] dpx [NS+1], dpy [NS+1], dlx [NS+1], dly [NS+1];

  assign dv[0] = v3; assign drej[0] = rej3; assign dq[0] = '0; assign drm[0] = '0;
  assign dn[0] = num3; assign dd[0] = den3;
  assign dpx[0] = px3; assign dpy[0] = py3; assign dlx[0] = lx3; assign dly[0] = ly3;

  for (genvar g = 0; g < NS; g++) begin : g_div
    logic [CW+1:0] tr;
    assign tr = {drm[g], dn[g][KW-1-g]};
    always_ff @(posedge clk) begin
      if (rst) dv[g+1] <= 1'b0;
      else if (adv) dv[g+1] <= dv[g];
      if (adv) begin
        if (tr >= {1'b0, dd[g]}) begin
          drm[g+1] <= (CW+1)'(tr - {1'b0, dd[g]});
          dq[g+1]  <= {dq[g][KW-2:0], 1'b1};
        end else begin
          drm[g+1] <= tr[CW:0];
          dq[g+1]  <= {dq[g][KW-2:0], 1'b0};
        end
        drej[g+1] <= drej[g]; dn[g+1] <= dn[g]; dd[g+1] <= dd[g];
        dpx[g+1] <= dpx[g]; dpy[g+1] <= dpy[g]; dlx[g+1] <= dlx[g]; dly[g+1] <= dly[g];
      end
    end
  end

  // Stage A: products of k with local direction (split high and low parts of k).
  localparam int KH = KW - FB;
  logic [KW-1:0] k;
  assign k = dq[NS];
  logic va, reja;
  logic signed [KH+CW:0] bxa, bya;
  logic signed [FB+CW:0] sxa, sya;
  logic signed [CW-1:0] pxa, pya;
  logic [KW-1:0] ka;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (adv) va <= dv[NS];
    if (adv) begin
      reja <= drej[NS];
      bxa <= signed'({1'b0, k[KW-1:FB]}) * dlx[NS];
      bya <= signed'({1'b0, k[KW-1:FB]}) * dly[NS];
      sxa <= signed'({1'b0, k[FB-1:0]}) * dlx[NS];
      sya <= signed'({1'b0, k[FB-1:0]}) * dly[NS];
      pxa <= dpx[NS]; pya <= dpy[NS]; ka <= k;
    end
  end

  // Stage B: hit point sums.
  localparam int HW = KH + CW + 3;
  logic vb, rejb;
  logic signed [HW-1:0] hx, hy;
  logic [KW-1:0] kb;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (adv) vb <= va;
    if (adv) begin
      rejb <= reja; kb <= ka;
      hx <= HW'(pxa) + HW'(bxa) + HW'(sxa >>> FB);
      hy <= HW'(pya) + HW'(bya) + HW'(sya >>> FB);
    end
  end

  // Stage C: bounds test and saturation into the output word.
  logic signed [HW-1:0] hwd, hhd;
  assign hwd = HW'({rw, {FB{1'b0}}} >> 1);
  assign hhd = HW'({rh, {FB{1'b0}}} >> 1);
  logic okc;
  assign okc = !rejb && !(hx > hwd || hx < -hwd) && !(hy > hhd || hy < -hhd);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vb;
    if (adv) begin
      hit <= okc;
      distance <= !okc ? '0 : ((kb > KW'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : kb[30:0]);
    end
  end

`ifndef SYNTHESIS
  a_no_dist_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> distance == '0) else $error("distance without hit");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(hit))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready)) else $error("ready not tied to output");
`endif

endmodule
`default_nettype wire
